/* src/arbm_pkg.sv */
`default_nettype none
package arbm_pkg;
  localparam int RATIO_BITS = 28;
  localparam int WIDEN_Q16 = 66;
  localparam logic [RATIO_BITS-1:0] RATIO_ONES = '1;

  // Divider job types
  localparam logic [1:0] DIV_RATIO = 2'd0;
  localparam logic [1:0] DIV_BIN = 2'd1;
  localparam logic [1:0] DIV_MEAN = 2'd2;

  // Controller commands to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic span_start;
    logic scan_rd;
    logic scan_start;
    logic scan_acc;
    logic mean_start;
    logic mean_sel_h;
    logic mean_latch;
    logic range_start;
    logic range_sel_hi;
    logic range_latch;
  } arbm_cmd_t;

  // Datapath status to controller
  typedef struct packed {
    logic div_busy;
    logic load_busy;
    logic mul_busy;
  } arbm_sts_t;
endpackage
`default_nettype wire

/* src/arbm_if.sv */
`default_nettype none
interface arbm_box_if #(parameter int COORD_BITS = 12) ();
  logic valid;
  logic ready;
  logic [COORD_BITS-1:0] box_left;
  logic [COORD_BITS-1:0] box_right;
  logic [COORD_BITS-1:0] box_top;
  logic [COORD_BITS-1:0] box_bottom;
  logic final_box;
  modport source (output valid, box_left, box_right, box_top, box_bottom, final_box,
    input ready);
  modport sink (input valid, box_left, box_right, box_top, box_bottom, final_box,
    output ready);
endinterface

interface arbm_res_if #(parameter int COORD_BITS = 12, parameter int IDX_BITS = 4) ();
  logic valid;
  logic ready;
  logic [IDX_BITS-1:0] bin_index;
  logic [COORD_BITS-1:0] mean_width;
  logic [COORD_BITS-1:0] mean_height;
  logic [27:0] ratio_low;
  logic [27:0] ratio_high;
  logic boxes_dropped;
  logic last_bin;
  modport source (output valid, bin_index, mean_width, mean_height, ratio_low,
    ratio_high, boxes_dropped, last_bin, input ready);
  modport sink (input valid, bin_index, mean_width, mean_height, ratio_low,
    ratio_high, boxes_dropped, last_bin, output ready);
endinterface

interface arbm_cfg_if ();
  logic valid;
  logic ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* src/arbm_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module arbm_div #(
  parameter int NUM_BITS = 44,
  parameter int DEN_BITS = 28
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic                     busy,
  output logic [NUM_BITS-1:0]      quot
);
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS:0] rem;
  logic [DEN_BITS-1:0] dreg;
  logic [DEN_BITS+1:0] trial;

  assign trial = {rem, quot[NUM_BITS-1]} - {2'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_BITS'(NUM_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) busy <= 1'b0;
    end
  end

  // shift numerator bits through the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem <= '0;
      dreg <= den;
    end else if (busy) begin
      if (!trial[DEN_BITS+1]) begin
        rem <= trial[DEN_BITS:0];
        quot <= {quot[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[DEN_BITS-1:0], quot[NUM_BITS-1]};
        quot <= {quot[NUM_BITS-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

/* src/arbm_datapath.sv */
`default_nettype none
module arbm_datapath #(
  parameter int MAX_BOXES = 1024,
  parameter int MAX_BINS = 16,
  parameter int COORD_BITS = 12,
  parameter int CNT_BITS = 11,
  parameter int BIN_BITS = 4,
  parameter int NB_BITS = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire arbm_pkg::arbm_cmd_t   cmd,
  output arbm_pkg::arbm_sts_t        sts,
  input  wire logic [COORD_BITS-1:0] in_left,
  input  wire logic [COORD_BITS-1:0] in_right,
  input  wire logic [COORD_BITS-1:0] in_top,
  input  wire logic [COORD_BITS-1:0] in_bottom,
  input  wire logic [NB_BITS-1:0]    nbins,
  input  wire logic [BIN_BITS-1:0]   bin_sel,
  input  wire logic [CNT_BITS-1:0]   scan_idx,
  output logic [CNT_BITS-1:0]        box_total,
  output logic [COORD_BITS-1:0]      mean_w,
  output logic [COORD_BITS-1:0]      mean_h,
  output logic [27:0]                r_lo,
  output logic [27:0]                r_hi,
  output logic                       dropped
);
  import arbm_pkg::*;
  localparam int ADDR_BITS = $clog2(MAX_BOXES);
  localparam int SUM_BITS = COORD_BITS + CNT_BITS;
  localparam int NUM_BITS = (SUM_BITS > 44) ? SUM_BITS : 44;
  localparam int PROD_BITS = RATIO_BITS + NB_BITS + 1;

  logic [2*COORD_BITS-1:0] store [MAX_BOXES];
  logic [2*COORD_BITS-1:0] rd_q;
  logic [RATIO_BITS-1:0] rmin, rmax, lo, span, interval;
  logic [SUM_BITS-1:0] wsum [MAX_BINS];
  logic [SUM_BITS-1:0] hsum [MAX_BINS];
  logic [CNT_BITS-1:0] memb [MAX_BINS];

  // load pipeline: stage of pending box for the ratio divider
  logic [COORD_BITS-1:0] lw, lh;
  logic lpend;
  logic [COORD_BITS-1:0] w_in, h_in;
  logic box_ok;

  // one shared divider
  logic d_start;
  logic [NUM_BITS-1:0] d_num;
  logic [RATIO_BITS-1:0] d_den;
  logic d_busy;
  logic [NUM_BITS-1:0] d_q;
  logic [1:0] d_job;

  arbm_div #(.NUM_BITS(NUM_BITS), .DEN_BITS(RATIO_BITS)) u_div (
    .clk(clk), .rst(rst), .start(d_start), .num(d_num), .den(d_den),
    .busy(d_busy), .quot(d_q)
  );

  assign w_in = in_right - in_left;
  assign h_in = in_bottom - in_top;
  assign box_ok = (in_right > in_left) && (in_bottom >= in_top);

  // scan: current stored box
  logic [COORD_BITS-1:0] sw, sh;
  assign sw = rd_q[COORD_BITS-1:0];
  assign sh = rd_q[2*COORD_BITS-1:COORD_BITS];
  logic [RATIO_BITS-1:0] sratio;
  logic sstep; // 0: ratio div, 1: bin div

  // range multiplier stage
  logic [PROD_BITS-1:0] prod;
  logic mul_busy;

  // divider request mux
  always_comb begin
    d_start = 1'b0;
    d_num = '0;
    d_den = '0;
    if (lpend && !d_busy && d_job == DIV_RATIO) begin
      d_start = 1'b1;
      d_num = NUM_BITS'({lh, 16'b0});
      d_den = RATIO_BITS'(lw);
    end else if (cmd.span_start) begin
      d_start = 1'b1;
      d_num = NUM_BITS'(span);
      d_den = RATIO_BITS'(nbins);
    end else if (cmd.scan_start) begin
      d_start = 1'b1;
      d_num = NUM_BITS'({sh, 16'b0});
      d_den = RATIO_BITS'(sw);
    end else if (sstep) begin
      d_start = 1'b1;
      d_num = NUM_BITS'(sratio - lo);
      d_den = interval;
    end else if (cmd.mean_start) begin
      d_start = 1'b1;
      d_num = NUM_BITS'(cmd.mean_sel_h ? hsum[bin_sel] : wsum[bin_sel]);
      d_den = RATIO_BITS'(memb[bin_sel]);
    end else if (mul_busy) begin
      d_start = 1'b1;
      d_num = NUM_BITS'(prod);
      d_den = RATIO_BITS'(nbins);
    end
  end

  assign sts.div_busy = d_busy || d_start || sstep;
  assign sts.load_busy = lpend || (d_busy && d_job == DIV_RATIO);
  assign sts.mul_busy = mul_busy;
  assign dropped = 1'b0 ^ dropped_q;
  logic dropped_q;

  assign lo = (box_total == '0) ? '0 : rmin;
  assign span = ((box_total == '0) ? '0 : rmax) - lo;

  // memory and load path
  always_ff @(posedge clk) begin
    if (cmd.load && box_ok && box_total < CNT_BITS'(MAX_BOXES))
      store[box_total[ADDR_BITS-1:0]] <= {h_in, w_in};
    if (cmd.scan_rd) rd_q <= store[scan_idx[ADDR_BITS-1:0]];
  end

  logic [BIN_BITS-1:0] bsel;
  logic [NUM_BITS-1:0] bq;
  assign bq = (d_q >= NUM_BITS'(nbins - 1'b1)) ? NUM_BITS'(nbins - 1'b1) : d_q;
  assign bsel = bq[BIN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      box_total <= '0;
      rmin <= RATIO_ONES;
      rmax <= '0;
      dropped_q <= 1'b0;
      lpend <= 1'b0;
      d_job <= DIV_RATIO;
      sstep <= 1'b0;
      mul_busy <= 1'b0;
      for (int k = 0; k < MAX_BINS; k++) begin
        wsum[k] <= '0; hsum[k] <= '0; memb[k] <= '0;
      end
    end else begin
      sstep <= 1'b0;
      if (cmd.load && box_ok) begin
        if (box_total < CNT_BITS'(MAX_BOXES)) begin
          box_total <= box_total + 1'b1;
          lw <= w_in; lh <= h_in; lpend <= 1'b1;
        end else dropped_q <= 1'b1;
      end
      if (lpend && !d_busy && d_job == DIV_RATIO) begin
        lpend <= 1'b0;
      end
      // ratio result of a load finishes: update min and max
      if (d_busy && d_job == DIV_RATIO && !lpend) begin
      end
      if (d_start) begin
        if (lpend && !d_busy && d_job == DIV_RATIO) d_job <= DIV_RATIO;
        else if (cmd.scan_start) d_job <= DIV_BIN;
        else if (sstep) d_job <= DIV_BIN;
        else d_job <= DIV_MEAN;
      end
      if (cmd.span_start || cmd.mean_start || mul_busy) mul_busy <= 1'b0;
      if (cmd.range_start) mul_busy <= 1'b1;
      // scan ratio done: start bin division
      if (cmd.scan_acc && !sstep) begin
        sratio <= d_q[RATIO_BITS-1:0];
        sstep <= 1'b1;
      end
      if (cmd.scan_acc && sstep) begin
      end
      if (cmd.clear) begin
        box_total <= '0;
        rmin <= RATIO_ONES;
        rmax <= '0;
        dropped_q <= 1'b0;
        d_job <= DIV_RATIO;
        for (int k = 0; k < MAX_BINS; k++) begin
          wsum[k] <= '0; hsum[k] <= '0; memb[k] <= '0;
        end
      end
      if (ratio_done) begin
        if (d_q[RATIO_BITS-1:0] < rmin) rmin <= d_q[RATIO_BITS-1:0];
        if (d_q[RATIO_BITS-1:0] > rmax) rmax <= d_q[RATIO_BITS-1:0];
      end
      if (bin_done) begin
        wsum[bsel] <= wsum[bsel] + SUM_BITS'(sw);
        hsum[bsel] <= hsum[bsel] + SUM_BITS'(sh);
        memb[bsel] <= memb[bsel] + 1'b1;
      end
    end
  end

  // completion detection of divider jobs
  logic d_busy_q;
  logic ratio_done, bin_done;
  always_ff @(posedge clk) begin
    if (rst) d_busy_q <= 1'b0;
    else d_busy_q <= d_busy;
  end
  logic [1:0] bin_phase;
  assign ratio_done = d_busy_q && !d_busy && d_job == DIV_RATIO;
  assign bin_done = d_busy_q && !d_busy && d_job == DIV_BIN && bin_phase == 2'd1;

  // scan phase tracking: first bin-job divide is ratio, second is bin index
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) bin_phase <= 2'd0;
    else if (cmd.scan_start) bin_phase <= 2'd0;
    else if (sstep) bin_phase <= 2'd1;
  end

  // interval, means and range results
  always_ff @(posedge clk) begin
    if (cmd.span_start) interval <= '0;
    else if (d_busy_q && !d_busy && d_job == DIV_MEAN && !cmd.mean_latch
             && !cmd.range_latch && interval == '0)
      interval <= d_q[RATIO_BITS-1:0] + RATIO_BITS'(WIDEN_Q16);
    if (cmd.range_start)
      prod <= PROD_BITS'(span) * PROD_BITS'(cmd.range_sel_hi ? bin_sel + 1'b1 : bin_sel);
    if (cmd.mean_latch) begin
      if (memb[bin_sel] == '0) begin
        if (cmd.mean_sel_h) mean_h <= '0; else mean_w <= '0;
      end else if (cmd.mean_sel_h) mean_h <= d_q[COORD_BITS-1:0];
      else mean_w <= d_q[COORD_BITS-1:0];
    end
    if (cmd.range_latch) begin
      if (cmd.range_sel_hi) r_hi <= lo + d_q[RATIO_BITS-1:0];
      else r_lo <= lo + d_q[RATIO_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

/* src/arbm_ctrl.sv */
`default_nettype none
module arbm_ctrl #(
  parameter int CNT_BITS = 11,
  parameter int BIN_BITS = 4,
  parameter int NB_BITS = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_final,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire logic [NB_BITS-1:0]  nbins,
  input  wire logic [CNT_BITS-1:0] box_total,
  input  wire arbm_pkg::arbm_sts_t sts,
  output arbm_pkg::arbm_cmd_t      cmd,
  output logic [BIN_BITS-1:0]      bin_sel,
  output logic [CNT_BITS-1:0]      scan_idx,
  output logic                     last_bin
);
  import arbm_pkg::*;
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_DRAIN = 4'd1;
  localparam logic [3:0] S_SPAN  = 4'd2;
  localparam logic [3:0] S_SPANW = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_RAT   = 4'd5;
  localparam logic [3:0] S_RATW  = 4'd6;
  localparam logic [3:0] S_BINW  = 4'd7;
  localparam logic [3:0] S_MEAN  = 4'd8;
  localparam logic [3:0] S_MEANW = 4'd9;
  localparam logic [3:0] S_RNG   = 4'd10;
  localparam logic [3:0] S_RNGM  = 4'd11;
  localparam logic [3:0] S_RNGW  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;
  logic hsel;
  logic [1:0] wait_cnt;

  assign in_ready = (state == S_LOAD) && !sts.load_busy;
  assign out_valid = (state == S_OUT);
  assign last_bin = ({1'b0, bin_sel} + 1'b1) == (BIN_BITS+1)'(nbins);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    cmd.mean_sel_h = hsel;
    cmd.range_sel_hi = hsel;
    case (state)
      S_SPAN:  cmd.span_start = 1'b1;
      S_RD:    cmd.scan_rd = 1'b1;
      S_RAT:   cmd.scan_start = 1'b1;
      S_RATW:  cmd.scan_acc = !sts.div_busy && wait_cnt == 2'd0;
      S_MEAN:  cmd.mean_start = 1'b1;
      S_MEANW: cmd.mean_latch = !sts.div_busy && wait_cnt == 2'd0;
      S_RNG:   cmd.range_start = 1'b1;
      S_RNGW:  cmd.range_latch = !sts.div_busy && wait_cnt == 2'd0;
      S_OUT:   cmd.clear = out_ready && last_bin;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      bin_sel <= '0;
      scan_idx <= '0;
      hsel <= 1'b0;
      wait_cnt <= '0;
    end else begin
      if (wait_cnt != 2'd0) wait_cnt <= wait_cnt - 1'b1;
      case (state)
        S_LOAD: if (in_valid && in_ready && in_final) state <= S_DRAIN;
        S_DRAIN: if (!sts.load_busy && !sts.div_busy) state <= S_SPAN;
        S_SPAN: begin state <= S_SPANW; wait_cnt <= 2'd1; end
        S_SPANW: if (!sts.div_busy && wait_cnt == 2'd0) begin
          scan_idx <= '0;
          state <= (box_total == '0) ? S_MEAN : S_RD;
          bin_sel <= '0; hsel <= 1'b0;
        end
        S_RD: state <= S_RAT;
        S_RAT: begin state <= S_RATW; wait_cnt <= 2'd1; end
        S_RATW: if (!sts.div_busy && wait_cnt == 2'd0) begin
          state <= S_BINW; wait_cnt <= 2'd2;
        end
        S_BINW: if (!sts.div_busy && wait_cnt == 2'd0) begin
          if (scan_idx + 1'b1 == box_total) begin
            state <= S_MEAN; bin_sel <= '0; hsel <= 1'b0;
          end else begin
            scan_idx <= scan_idx + 1'b1; state <= S_RD;
          end
        end
        S_MEAN: begin state <= S_MEANW; wait_cnt <= 2'd1; end
        S_MEANW: if (!sts.div_busy && wait_cnt == 2'd0) begin
          hsel <= !hsel;
          state <= hsel ? S_RNG : S_MEAN;
        end
        S_RNG: state <= S_RNGM;
        S_RNGM: begin state <= S_RNGW; wait_cnt <= 2'd1; end
        S_RNGW: if (!sts.div_busy && !sts.mul_busy && wait_cnt == 2'd0) begin
          hsel <= !hsel;
          state <= hsel ? S_OUT : S_RNG;
        end
        S_OUT: if (out_ready) begin
          hsel <= 1'b0;
          if (last_bin) state <= S_LOAD;
          else begin bin_sel <= bin_sel + 1'b1; state <= S_MEAN; end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/aspect_ratio_bin_means.sv */
`default_nettype none
// Aspect-ratio bin means.
// Boxes arrive on box_in while loading; each valid box's width and height
// go to a box memory and a shared radix-2 divider works out its Q12.16
// height/width ratio to track min and max. The item flagged with final_box
// closes the set. Then the controller sweeps the stored boxes, and for each
// bin computes two means and two range bounds before offering one item on
// res_out. All these divisions run on the shared 44-bit divider. In loading,
// the divider must finish each box's ratio before the next box is taken.
// cfg_in writes bin_count (5 bits); values 0 and above MAX_BINS clamp.
// A stalled res_out holds the current result; no further work is done.
// After the last bin is taken the set state is cleared and loading resumes.
// Reset (rst, synchronous) empties the set and sets bin_count to 1.
module aspect_ratio_bin_means #(
  parameter int MAX_BOXES = 1024,
  parameter int MAX_BINS = 16,
  parameter int COORD_BITS = 12
) (
  input wire logic clk,
  input wire logic rst,
  arbm_box_if.sink box_in,
  arbm_res_if.source res_out,
  arbm_cfg_if.sink cfg_in
);
  import arbm_pkg::*;
  localparam int CNT_BITS = $clog2(MAX_BOXES + 1);
  localparam int BIN_BITS = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NB_BITS = $clog2(MAX_BINS + 1);

  logic [4:0] bin_count;
  logic [NB_BITS-1:0] nbins;
  arbm_cmd_t cmd;
  arbm_sts_t sts;
  logic [BIN_BITS-1:0] bin_sel;
  logic [CNT_BITS-1:0] scan_idx, box_total;
  logic [COORD_BITS-1:0] mean_w, mean_h;
  logic [27:0] r_lo, r_hi;
  logic dropped, last_bin;

  // bin count register
  assign cfg_in.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bin_count <= 5'd1;
    else if (cfg_in.valid) bin_count <= cfg_in.data;
  end
  always_comb begin
    if (bin_count == 5'd0) nbins = NB_BITS'(1);
    else if (32'(bin_count) > MAX_BINS) nbins = NB_BITS'(MAX_BINS);
    else nbins = NB_BITS'(bin_count);
  end

  arbm_ctrl #(.CNT_BITS(CNT_BITS), .BIN_BITS(BIN_BITS), .NB_BITS(NB_BITS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(box_in.valid), .in_ready(box_in.ready),
    .in_final(box_in.final_box), .out_valid(res_out.valid), .out_ready(res_out.ready),
    .nbins(nbins), .box_total(box_total), .sts(sts), .cmd(cmd), .bin_sel(bin_sel),
    .scan_idx(scan_idx), .last_bin(last_bin)
  );

  arbm_datapath #(.MAX_BOXES(MAX_BOXES), .MAX_BINS(MAX_BINS), .COORD_BITS(COORD_BITS),
    .CNT_BITS(CNT_BITS), .BIN_BITS(BIN_BITS), .NB_BITS(NB_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_left(box_in.box_left),
    .in_right(box_in.box_right), .in_top(box_in.box_top), .in_bottom(box_in.box_bottom),
    .nbins(nbins), .bin_sel(bin_sel), .scan_idx(scan_idx), .box_total(box_total),
    .mean_w(mean_w), .mean_h(mean_h), .r_lo(r_lo), .r_hi(r_hi), .dropped(dropped)
  );

  assign res_out.bin_index = 4'(bin_sel);
  assign res_out.mean_width = mean_w;
  assign res_out.mean_height = mean_h;
  assign res_out.ratio_low = r_lo;
  assign res_out.ratio_high = r_hi;
  assign res_out.boxes_dropped = dropped;
  assign res_out.last_bin = last_bin;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(box_in.ready && res_out.valid)) else $error("load while emitting");
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    box_total <= CNT_BITS'(MAX_BOXES)) else $error("box count over capacity");
  a_low_le_high: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> res_out.ratio_low <= res_out.ratio_high)
    else $error("range inverted");
`endif
endmodule
`default_nettype wire
